// ----- rtl/core/gregorian_date_add_days_top_macros.svh -----
// assertion macros for the checker of the date adder
`ifndef GREGORIAN_DATE_ADD_DAYS_TOP_MACROS_SVH
`define GREGORIAN_DATE_ADD_DAYS_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define GDA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gda check failed: same-cycle implication");

// next-cycle implication, sampled on clk, off while rst is high
`define GDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gda check failed: next-cycle implication");

`endif

// ----- rtl/core/gda_pkg.sv -----
package gda_pkg;

  // width of the day count
  localparam int ADD_WIDTH = 20;

  // calendar constants
  localparam int CYCLE_DAYS  = 146097;
  localparam int CYCLE_YEARS = 400;
  localparam int YEAR_MAX    = 9999;
  localparam int MONTHS      = 12;
  localparam int MONTH_CAP   = 13;

  // day-of-year plus day count stays below 2^(ADD_WIDTH+2)
  localparam int REM_WIDTH  = ADD_WIDTH + 2;
  // one bit more than the widest operand, the top bit is the borrow
  localparam int UNIT_WIDTH = ((REM_WIDTH > 18) ? REM_WIDTH : 18) + 1;
  // bits of the 400-year cycle count
  localparam int QUO_WIDTH  = (ADD_WIDTH > 15) ? ADD_WIDTH - 15 : 1;
  // bits of the quotient of a 14-bit year by 400
  localparam int MOD_STEPS  = 6;
  localparam int IDX_WIDTH  = $clog2((QUO_WIDTH > MOD_STEPS) ? QUO_WIDTH : MOD_STEPS);
  localparam int YEAR_WIDTH = (((QUO_WIDTH + 9) > 14) ? (QUO_WIDTH + 9) : 14) + 1;

  typedef struct packed {
    logic [4:0]           start_day;
    logic [3:0]           start_month;
    logic [13:0]          start_year;
    logic [ADD_WIDTH-1:0] days_to_add;
  } in_t;

  typedef struct packed {
    logic [4:0]  end_day;
    logic [3:0]  end_month;
    logic [13:0] end_year;
    logic        year_overflow;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SUM,
    ST_ADD,
    ST_DIV,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } gda_state_t;

  // length of month m (1..12)
  function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2: begin
        len = leap ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        len = 5'd30;
      end
      default: begin
        len = 5'd31;
      end
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/core/gregorian_date_add_days_top.sv -----
// Gregorian date adder: a request carries a start date (day, month, year) and a day
// count; one result returns the date that many days later, with the year held at
// 9999 and year_overflow set when the true year goes past it. Out-of-range days
// and months roll over as a calendar would (day 0 is the last day of the month
// before, but stays day 0 in January; month 0 is January, month 13 and above is
// January of the next year). Every step runs on one shared add/subtract-compare
// unit, one operation per clock while the output is free: reduce the start year
// modulo 400 one quotient bit at a time, sum the lengths of the months before
// the start month, add the count, take off whole 400-year cycles (one quotient
// bit each), then step through the remaining years and then the months, and
// hand off the result. in_ready is low from acceptance until the result is in
// the output register; a result waiting there does not stop the next request
// from being taken.
module gregorian_date_add_days_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  gda_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output gda_pkg::out_t out_data
);

  localparam int UW = gda_pkg::UNIT_WIDTH;
  localparam int RW = gda_pkg::REM_WIDTH;
  localparam int YW = gda_pkg::YEAR_WIDTH;
  localparam int IW = gda_pkg::IDX_WIDTH;

  gda_pkg::gda_state_t state, state_next;

  logic [RW-1:0]                 rem;
  logic [YW-1:0]                 year;
  logic [13:0]                   ymod;
  logic [3:0]                    mon;
  logic [3:0]                    stop_mon;
  logic [IW-1:0]                 idx;
  logic [gda_pkg::ADD_WIDTH-1:0] add_q;

  logic          leap;
  logic [4:0]    mdays;
  logic [8:0]    ydays;
  logic [UW-1:0] op_a, op_b, unit_res;
  logic          op_sub;
  logic          ge, gt;
  logic          load;
  logic          ovf;
  gda_pkg::out_t result;

  // leap rule on the year modulo 400
  assign leap  = (ymod[1:0] == 2'b00) && (ymod != 14'd100) && (ymod != 14'd200)
                 && (ymod != 14'd300);
  assign mdays = gda_pkg::month_length(mon, leap);
  assign ydays = leap ? 9'd366 : 9'd365;

  // operand select for the shared unit
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    case (state)
      gda_pkg::ST_MOD: begin
        op_a   = UW'(ymod);
        op_b   = UW'(gda_pkg::CYCLE_YEARS) << idx;
        op_sub = 1'b1;
      end
      gda_pkg::ST_SUM: begin
        op_a = UW'(rem);
        op_b = UW'(mdays);
      end
      gda_pkg::ST_ADD: begin
        op_a = UW'(rem);
        op_b = UW'(add_q);
      end
      gda_pkg::ST_DIV: begin
        op_a   = UW'(rem);
        op_b   = UW'(gda_pkg::CYCLE_DAYS) << idx;
        op_sub = 1'b1;
      end
      gda_pkg::ST_YEAR: begin
        op_a   = UW'(rem);
        op_b   = UW'(ydays);
        op_sub = 1'b1;
      end
      gda_pkg::ST_MONTH: begin
        op_a   = UW'(rem);
        op_b   = UW'(mdays);
        op_sub = 1'b1;
      end
      default: begin
        op_a   = '0;
        op_b   = '0;
        op_sub = 1'b0;
      end
    endcase
  end

  // shared add/subtract with compare flags
  assign unit_res = op_sub ? (op_a - op_b) : (op_a + op_b);
  assign ge       = !unit_res[UW-1];
  assign gt       = ge && (unit_res[UW-2:0] != '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gda_pkg::ST_IDLE: begin
        if (in_valid) state_next = gda_pkg::ST_MOD;
      end
      gda_pkg::ST_MOD: begin
        if (idx == '0) state_next = gda_pkg::ST_SUM;
      end
      gda_pkg::ST_SUM: begin
        if (mon >= stop_mon) state_next = gda_pkg::ST_ADD;
      end
      gda_pkg::ST_ADD: begin
        state_next = gda_pkg::ST_DIV;
      end
      gda_pkg::ST_DIV: begin
        if (idx == '0) state_next = gda_pkg::ST_YEAR;
      end
      gda_pkg::ST_YEAR: begin
        if (!gt) state_next = gda_pkg::ST_MONTH;
      end
      gda_pkg::ST_MONTH: begin
        if ((mon == 4'(gda_pkg::MONTHS)) || !gt) state_next = gda_pkg::ST_DONE;
      end
      gda_pkg::ST_DONE: begin
        if (!out_valid || out_ready) state_next = gda_pkg::ST_IDLE;
      end
      default: begin
        state_next = gda_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = (state == gda_pkg::ST_IDLE);
    load     = (state == gda_pkg::ST_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gda_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      gda_pkg::ST_IDLE: begin
        if (in_valid) begin
          rem      <= RW'(in_data.start_day);
          ymod     <= in_data.start_year;
          year     <= YW'(in_data.start_year);
          mon      <= 4'd1;
          stop_mon <= (in_data.start_month > 4'(gda_pkg::MONTH_CAP)) ?
                      4'(gda_pkg::MONTH_CAP) : in_data.start_month;
          add_q    <= in_data.days_to_add;
          idx      <= IW'(gda_pkg::MOD_STEPS - 1);
        end
      end
      gda_pkg::ST_MOD: begin
        if (ge) ymod <= unit_res[13:0];
        idx <= idx - 1'b1;
      end
      gda_pkg::ST_SUM: begin
        if (mon < stop_mon) begin
          rem <= unit_res[RW-1:0];
          mon <= mon + 1'b1;
        end
      end
      gda_pkg::ST_ADD: begin
        rem <= unit_res[RW-1:0];
        mon <= 4'd1;
        idx <= IW'(gda_pkg::QUO_WIDTH - 1);
      end
      gda_pkg::ST_DIV: begin
        // one quotient bit of the 400-year cycle count
        if (gt) begin
          rem  <= unit_res[RW-1:0];
          year <= year + (YW'(gda_pkg::CYCLE_YEARS) << idx);
        end
        idx <= idx - 1'b1;
      end
      gda_pkg::ST_YEAR: begin
        if (gt) begin
          rem  <= unit_res[RW-1:0];
          year <= year + 1'b1;
          ymod <= (ymod == 14'(gda_pkg::CYCLE_YEARS - 1)) ? '0 : ymod + 1'b1;
        end
      end
      gda_pkg::ST_MONTH: begin
        if ((mon != 4'(gda_pkg::MONTHS)) && gt) begin
          rem <= unit_res[RW-1:0];
          mon <= mon + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // result with year saturation
  assign ovf = year > YW'(gda_pkg::YEAR_MAX);
  always_comb begin
    result.end_day       = rem[4:0];
    result.end_month     = mon;
    result.end_year      = ovf ? 14'(gda_pkg::YEAR_MAX) : year[13:0];
    result.year_overflow = ovf;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= result;
  end

endmodule

// ----- rtl/core/gda_checker.sv -----
`include "gregorian_date_add_days_top_macros.svh"

module gda_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input gda_pkg::out_t out_data
);

  // one request at a time: no second accept right after one
  `GDA_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)

  // a stalled result holds
  `GDA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // month always lands in 1..12
  `GDA_ASSERT_NOW(a_month_range, out_valid, (out_data.end_month >= 4'd1) && (out_data.end_month <= 4'd12))

  // overflow comes with a saturated year
  `GDA_ASSERT_NOW(a_ovf_sat, out_valid && out_data.year_overflow, out_data.end_year == 14'd9999)

endmodule

bind gregorian_date_add_days_top gda_checker u_gda_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- test/gda_date_checker.sv -----
`timescale 1ns / 1ps

module gda_date_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  gda_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  gda_pkg::out_t out_data,
  output int            mismatches,
  output int            pending,
  output int            checked,
  output int            overflows
);

  gda_pkg::out_t expected_dates[$];
  int            err_count;
  int            date_count;
  int            ovf_count;

  // gregorian leap rule on the widened year
  function automatic bit is_leap(input longint unsigned yr);
    return ((yr % 4) == 0 && (yr % 100) != 0) || ((yr % 400) == 0);
  endfunction

  // length of month mon (1..12) in year yr
  function automatic int unsigned cal_month_len(input longint unsigned yr,
                                                input int unsigned mon);
    int unsigned len;
    case (mon)
      2: begin
        len = is_leap(yr) ? 29 : 28;
      end
      4, 6, 9, 11: begin
        len = 30;
      end
      default: begin
        len = 31;
      end
    endcase
    return len;
  endfunction

  // end date of one request
  function automatic gda_pkg::out_t predict_date(input gda_pkg::in_t req);
    longint unsigned rem;
    longint unsigned yr;
    longint unsigned cycles;
    int unsigned     upto;
    int unsigned     mon;
    bit              ovf;
    gda_pkg::out_t   res;
    yr   = req.start_year;
    rem  = req.start_day;
    // months past twelve count as a thirteenth month
    upto = (req.start_month > gda_pkg::MONTH_CAP) ? gda_pkg::MONTH_CAP : req.start_month;
    for (mon = 1; mon < upto; mon++) begin
      rem += cal_month_len(yr, mon);
    end
    rem += req.days_to_add;
    // whole 400-year cycles first
    if (rem > gda_pkg::CYCLE_DAYS) begin
      cycles = (rem - 1) / gda_pkg::CYCLE_DAYS;
      rem -= cycles * gda_pkg::CYCLE_DAYS;
      yr  += cycles * gda_pkg::CYCLE_YEARS;
    end
    while (rem > (is_leap(yr) ? 366 : 365)) begin
      rem -= is_leap(yr) ? 366 : 365;
      yr++;
    end
    mon = 1;
    while (mon < gda_pkg::MONTHS && rem > cal_month_len(yr, mon)) begin
      rem -= cal_month_len(yr, mon);
      mon++;
    end
    ovf               = (yr > gda_pkg::YEAR_MAX);
    res.end_day       = 5'(rem);
    res.end_month     = 4'(mon);
    res.end_year      = ovf ? 14'(gda_pkg::YEAR_MAX) : 14'(yr);
    res.year_overflow = ovf;
    return res;
  endfunction

  task automatic report_field(input string field, input int want, input int got);
    err_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // compare results against the oldest prediction, then record new requests
  always @(posedge clk) begin
    gda_pkg::out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_dates.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d ovf %0d",
                   $time, out_data.end_day, out_data.end_month, out_data.end_year,
                   out_data.year_overflow);
        end else begin
          want = expected_dates.pop_front();
          date_count++;
          if (out_data.year_overflow) begin
            ovf_count++;
          end
          if (out_data.end_day !== want.end_day) begin
            report_field("end_day", want.end_day, out_data.end_day);
          end
          if (out_data.end_month !== want.end_month) begin
            report_field("end_month", want.end_month, out_data.end_month);
          end
          if (out_data.end_year !== want.end_year) begin
            report_field("end_year", want.end_year, out_data.end_year);
          end
          if (out_data.year_overflow !== want.year_overflow) begin
            report_field("year_overflow", want.year_overflow, out_data.year_overflow);
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_dates.push_back(predict_date(in_data));
      end
    end
    mismatches <= err_count;
    pending    <= expected_dates.size();
    checked    <= date_count;
    overflows  <= ovf_count;
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int ADD_W           = gda_pkg::ADD_WIDTH;
  localparam int RANDOM_REQUESTS = 1400;
  // wait after the last result, before the verdict
  localparam int DRAIN_CYCLES    = 500;
  localparam int CYCLE_LIMIT     = 3000000;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  gda_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  gda_pkg::out_t out_data;

  int          mismatches;
  int          pending;
  int          checked;
  int          overflows;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  int          sent        = 0;

  gda_pkg::in_t directed_reqs[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gregorian_date_add_days_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  gda_date_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .overflows  (overflows)
  );

  // cycle counter for the watchdog and the stall pattern
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // receiver: rotates between always ready, light and heavy random stalls, long stalls
  always @(posedge clk) begin
    case (cycle_count[10:9])
      2'd0: begin
        out_ready <= 1'b1;
      end
      2'd1: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      2'd2: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (stall_left != 0) begin
          out_ready  <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 40);
          end
        end
      end
    endcase
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
    end
    $display("timeout after %0d cycles, %0d results still outstanding", cycle_count, pending);
    $display("FAIL");
    $finish;
  end

  function automatic gda_pkg::in_t date_req(input int unsigned d, input int unsigned m,
                                            input int unsigned y, input int unsigned a);
    gda_pkg::in_t r;
    r.start_day   = 5'(d);
    r.start_month = 4'(m);
    r.start_year  = 14'(y);
    r.days_to_add = ADD_W'(a);
    return r;
  endfunction

  // mostly valid dates with day counts of mixed size, some raw noise
  function automatic gda_pkg::in_t random_request();
    gda_pkg::in_t r;
    int unsigned  mon;
    int unsigned  yr;
    int unsigned  add;
    int unsigned  len;
    int unsigned  sel;
    if ($urandom_range(0, 99) < 20) begin
      r.start_day   = 5'($urandom);
      r.start_month = 4'($urandom);
      r.start_year  = 14'($urandom);
      r.days_to_add = ADD_W'($urandom);
    end else begin
      mon = $urandom_range(1, 12);
      len = (mon == 2) ? 28 : ((mon == 4 || mon == 6 || mon == 9 || mon == 11) ? 30 : 31);
      sel = $urandom_range(0, 9);
      if (sel <= 5) begin
        yr = $urandom_range(1, 9999);
      end else if (sel == 6) begin
        yr = 100 * $urandom_range(1, 99);
      end else if (sel <= 8) begin
        yr = $urandom_range(9000, 9999);
      end else begin
        yr = $urandom_range(1, 400);
      end
      sel = $urandom_range(0, 9);
      if (sel <= 3) begin
        add = $urandom_range(0, 60);
      end else if (sel <= 5) begin
        add = $urandom_range(0, 800);
      end else if (sel <= 7) begin
        add = $urandom_range(0, 20000);
      end else if (sel == 8) begin
        add = $urandom;
      end else begin
        // right around a whole number of 400-year cycles
        add = $urandom_range(1, 7) * gda_pkg::CYCLE_DAYS - 1 + $urandom_range(0, 2);
      end
      r = date_req($urandom_range(1, len), mon, yr, add);
    end
    return r;
  endfunction

  task automatic send_request(input gda_pkg::in_t req);
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    sent++;
  endtask

  // stimulus and verdict
  initial begin
    int unsigned  burst_left;
    int unsigned  gap;
    int           total;
    gda_pkg::in_t req;
    directed_reqs.push_back(date_req(1, 1, 1, 0));
    directed_reqs.push_back(date_req(31, 12, 9999, 0));
    directed_reqs.push_back(date_req(31, 12, 9999, 1));
    directed_reqs.push_back(date_req(0, 1, 2000, 0));
    directed_reqs.push_back(date_req(31, 2, 2023, 0));
    directed_reqs.push_back(date_req(31, 2, 2024, 0));
    directed_reqs.push_back(date_req(15, 0, 2020, 10));
    directed_reqs.push_back(date_req(1, 13, 2020, 0));
    directed_reqs.push_back(date_req(1, 15, 2020, 0));
    directed_reqs.push_back(date_req(10, 6, 0, 100));
    directed_reqs.push_back(date_req(28, 2, 1900, 1));
    directed_reqs.push_back(date_req(28, 2, 2000, 1));
    directed_reqs.push_back(date_req(29, 2, 2100, 0));
    directed_reqs.push_back(date_req(1, 3, 2024, 365));
    directed_reqs.push_back(date_req(1, 1, 1, (1 << ADD_W) - 1));
    directed_reqs.push_back(date_req(31, 12, 9999, (1 << ADD_W) - 1));
    directed_reqs.push_back(date_req(1, 1, 16383, 0));
    directed_reqs.push_back(date_req(1, 1, 10000, 0));
    directed_reqs.push_back(date_req(1, 1, 1, gda_pkg::CYCLE_DAYS));
    directed_reqs.push_back(date_req(1, 1, 1, gda_pkg::CYCLE_DAYS - 1));
    directed_reqs.push_back(date_req(31, 15, 16383, (1 << ADD_W) - 1));
    directed_reqs.push_back(date_req(0, 0, 0, 0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender works in bursts with random gaps, some bursts back to back
    burst_left = 0;
    total      = directed_reqs.size() + RANDOM_REQUESTS;
    for (int i = 0; i < total; i++) begin
      req = (i < directed_reqs.size()) ? directed_reqs[i] : random_request();
      send_request(req);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    // wait for every outstanding result, then let the block settle
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d date requests (%0d directed), checked %0d results, %0d with overflow",
             sent, directed_reqs.size(), checked, overflows);
    $display("finished after %0d cycles with %0d mismatches", cycle_count, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
